FILE: sv/rlsf_pkg.sv
// rlsf_pkg: shared types and constants of the run length planar span fill core
// no dependencies
`default_nettype none

package rlsf_pkg;

  // default sizes of the frame memory and raster
  localparam int unsigned AddrBitsDef  = 16;
  localparam int unsigned RowBytesDef  = 40;
  localparam int unsigned MaxWidthDef  = 320;
  localparam int unsigned MaxHeightDef = 200;

  // frame memory layout
  localparam logic [15:0] PlaneFar  = 16'h0400;
  localparam int unsigned LineShift = 11;
  localparam logic [7:0]  ByteOnes  = 8'hFF;
  localparam logic [7:0]  ByteZeros = 8'h00;

  // register indexes
  localparam logic [1:0] RegPlaneBase = 2'd0;
  localparam logic [1:0] RegLineWidth = 2'd1;
  localparam logic [1:0] RegLineCount = 2'd2;

  // reset values of the registers
  localparam logic [15:0] PlaneBaseRst = 16'd0;
  localparam logic [8:0]  LineWidthRst = 9'd320;
  localparam logic [7:0]  LineCountRst = 8'd200;

  // result status codes
  localparam logic [1:0] StatNormal = 2'd0;
  localparam logic [1:0] StatFilled = 2'd1;
  localparam logic [1:0] StatLeft   = 2'd2;

  // item classes decided by the front
  typedef enum logic [1:0] {
    KIND_READ,
    KIND_ZERO,
    KIND_PAINT
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  level;
    logic [15:0] run_length;
    logic [15:0] read_address;
    logic        read_bank;
  } item_t;

endpackage

`default_nettype wire

FILE: sv/rlsf_front.sv
// rlsf_front: accepts input words, classifies them and holds them in a two entry queue
// depends on rlsf_pkg
`default_nettype none

module rlsf_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  output logic                   full_o,
  input  wire logic              command_i,
  input  wire logic [3:0]        level_i,
  input  wire logic [15:0]       run_length_i,
  input  wire logic [15:0]       read_address_i,
  input  wire logic              read_bank_i,
  input  wire logic              clearing_i,
  output logic                   avail_o,
  output rlsf_pkg::item_t        item_o,
  input  wire logic              take_i
);
  import rlsf_pkg::*;

  item_t      slot_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      item_in;
  logic       do_push, do_take;

  // no words are taken while the frame memory is being cleared
  assign full_o  = (cnt_q == 2'd2) || clearing_i;
  assign avail_o = (cnt_q != 2'd0);
  assign item_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_take = take_i && avail_o;

  // classify the incoming word
  always_comb begin
    item_in.level        = level_i;
    item_in.run_length   = run_length_i;
    item_in.read_address = read_address_i;
    item_in.read_bank    = read_bank_i;
    if (command_i) begin
      item_in.kind = KIND_READ;
    end else if (run_length_i == 16'd0) begin
      item_in.kind = KIND_ZERO;
    end else begin
      item_in.kind = KIND_PAINT;
    end
  end

  // queue pointers
  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_take;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_take};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= item_in;
    end
  end

endmodule

`default_nettype wire

FILE: sv/rlsf_back.sv
// rlsf_back: cursor, span sequencer, two bank frame memory and result register
// depends on rlsf_pkg
`default_nettype none

module rlsf_back #(
  parameter int unsigned ADDR_BITS  = rlsf_pkg::AddrBitsDef,
  parameter int unsigned ROW_BYTES  = rlsf_pkg::RowBytesDef,
  parameter int unsigned MAX_WIDTH  = rlsf_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = rlsf_pkg::MaxHeightDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [15:0]       cfg_data_i,
  input  wire logic              avail_i,
  input  rlsf_pkg::item_t        item_i,
  output logic                   take_o,
  output logic                   clearing_o,
  output logic                   empty_o,
  input  wire logic              pop_i,
  output logic [1:0]             status_o,
  output logic [15:0]            remaining_length_o,
  output logic [7:0]             read_data_o
);
  import rlsf_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned BW    = CW - 3;
  localparam int unsigned Depth = 1 << ADDR_BITS;

  localparam logic [3:0] StClr   = 4'd0;
  localparam logic [3:0] StIdle  = 4'd1;
  localparam logic [3:0] StDisp  = 4'd2;
  localparam logic [3:0] StRdW   = 4'd3;
  localparam logic [3:0] StSeg   = 4'd4;
  localparam logic [3:0] StPlane = 4'd5;
  localparam logic [3:0] StByte  = 4'd6;
  localparam logic [3:0] StMerge = 4'd7;
  localparam logic [3:0] StAdv   = 4'd8;
  localparam logic [3:0] StRes   = 4'd9;

  logic [3:0]           state_q, state_d;
  logic [ADDR_BITS:0]   clr_q, clr_d;
  logic [15:0]          base_q;
  logic [8:0]           lwidth_q;
  logic [7:0]           lcount_q;
  logic [CW-1:0]        cx_q, cx_d;
  logic [7:0]           cy_q, cy_d;
  item_t                item_q;
  logic [15:0]          len_q, len_d;
  logic [CW-1:0]        sx_q, sx_d, sn_q, sn_d, send_q, send_d;
  logic [ADDR_BITS-1:0] rel_q, rel_d, addr_q, addr_d;
  logic [BW-1:0]        bidx_q, bidx_d;
  logic [1:0]           plane_q, plane_d;
  logic [1:0]           rstat_q, rstat_d;
  logic [15:0]          rrem_q, rrem_d;
  logic [7:0]           rdat_q, rdat_d;
  logic                 ovalid_q;
  logic [1:0]           ostat_q;
  logic [15:0]          orem_q;
  logic [7:0]           odat_q;
  logic                 load_out;

  logic [7:0]           mem0 [Depth];
  logic [7:0]           mem1 [Depth];
  logic [ADDR_BITS-1:0] ra, wa;
  logic                 rsel, rsel_q, we0, we1;
  logic [7:0]           wd, rd0_q, rd1_q, rdata;

  logic [10:0]          wlim;
  logic [CW-1:0]        w_eff, xs, room;
  logic [7:0]           h_eff;
  logic [CW:0]          nx;
  logic [15:0]          relw;
  logic [2:0]           sbit, ebit;
  logic [7:0]           mask;
  logic                 pset, pbank;
  logic [BW-1:0]        first_b, last_b;

  // effective raster size
  always_comb begin
    wlim = {2'b0, lwidth_q};
    if (wlim == 11'd0) begin
      wlim = 11'd1;
    end
    if (wlim > 11'(MAX_WIDTH)) begin
      wlim = 11'(MAX_WIDTH);
    end
    w_eff = wlim[CW-1:0];
    h_eff = (lcount_q > 8'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : lcount_q;
  end

  // segment setup values
  always_comb begin
    xs   = (cx_q >= w_eff) ? '0 : cx_q;
    room = w_eff - xs;
    relw = 16'(xs[CW-1:3]) + (16'(cy_q[2:0]) << LineShift)
         + 16'(cy_q[7:3]) * 16'(ROW_BYTES);
    nx   = {1'b0, sx_q} + {1'b0, sn_q};
  end

  // byte mask of the current plane byte
  always_comb begin
    first_b = sx_q[CW-1:3];
    last_b  = send_q[CW-1:3];
    sbit    = (bidx_q == first_b) ? sx_q[2:0] : 3'd0;
    ebit    = (bidx_q == last_b) ? send_q[2:0] : 3'd7;
    mask    = (ByteOnes >> sbit) & (ByteOnes << (3'd7 - ebit));
    pset    = item_q.level[plane_q];
    pbank   = ~plane_q[1];
  end

  assign rdata    = rsel_q ? rd1_q : rd0_q;
  assign load_out = (state_q == StRes) && !ovalid_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cx_d    = cx_q;
    cy_d    = cy_q;
    len_d   = len_q;
    sx_d    = sx_q;
    sn_d    = sn_q;
    send_d  = send_q;
    rel_d   = rel_q;
    addr_d  = addr_q;
    bidx_d  = bidx_q;
    plane_d = plane_q;
    rstat_d = rstat_q;
    rrem_d  = rrem_q;
    rdat_d  = rdat_q;
    take_o  = 1'b0;
    ra      = addr_q;
    rsel    = pbank;
    we0     = 1'b0;
    we1     = 1'b0;
    wa      = addr_q;
    wd      = pset ? ByteOnes : ByteZeros;
    unique case (state_q)
      StClr: begin
        we0   = 1'b1;
        we1   = 1'b1;
        wa    = clr_q[ADDR_BITS-1:0];
        wd    = ByteZeros;
        clr_d = clr_q + 1'b1;
        if (clr_q[ADDR_BITS-1:0] == '1) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (avail_i) begin
          take_o  = 1'b1;
          state_d = StDisp;
        end
      end
      StDisp: begin
        rstat_d = StatNormal;
        rrem_d  = 16'd0;
        rdat_d  = 8'd0;
        len_d   = item_q.run_length;
        ra      = item_q.read_address[ADDR_BITS-1:0];
        rsel    = item_q.read_bank;
        unique case (item_q.kind)
          KIND_READ:  state_d = StRdW;
          KIND_ZERO:  state_d = StRes;
          KIND_PAINT: begin
            if (cy_q >= h_eff) begin
              rstat_d = StatLeft;
              rrem_d  = item_q.run_length;
              state_d = StRes;
            end else begin
              state_d = StSeg;
            end
          end
          default:    state_d = StRes;
        endcase
      end
      StRdW: begin
        rdat_d  = rdata;
        state_d = StRes;
      end
      StSeg: begin
        sx_d    = xs;
        sn_d    = (len_q < 16'(room)) ? len_q[CW-1:0] : room;
        send_d  = xs + sn_d - 1'b1;
        rel_d   = relw[ADDR_BITS-1:0];
        plane_d = 2'd0;
        state_d = StPlane;
      end
      StPlane: begin
        addr_d  = rel_q + (plane_q[0] ? '0 : PlaneFar[ADDR_BITS-1:0])
                + base_q[ADDR_BITS-1:0];
        bidx_d  = first_b;
        state_d = StByte;
      end
      StByte, StMerge: begin
        if (state_q == StByte && mask != ByteOnes) begin
          state_d = StMerge;
        end else begin
          if (state_q == StMerge) begin
            wd = (rdata & ~mask) | (pset ? mask : ByteZeros);
          end
          we0 = !pbank;
          we1 = pbank;
          if (bidx_q == last_b) begin
            if (plane_q == 2'd3) begin
              state_d = StAdv;
            end else begin
              plane_d = plane_q + 2'd1;
              state_d = StPlane;
            end
          end else begin
            bidx_d  = bidx_q + 1'b1;
            addr_d  = addr_q + 1'b1;
            state_d = StByte;
          end
        end
      end
      StAdv: begin
        len_d = len_q - 16'(sn_q);
        if (nx >= {1'b0, w_eff}) begin
          cx_d = '0;
          cy_d = cy_q + 8'd1;
          if (cy_d >= h_eff) begin
            rstat_d = (len_d == 16'd0) ? StatFilled : StatLeft;
            rrem_d  = len_d;
            state_d = StRes;
          end else if (len_d == 16'd0) begin
            state_d = StRes;
          end else begin
            state_d = StSeg;
          end
        end else begin
          cx_d    = nx[CW-1:0];
          state_d = StRes;
        end
      end
      StRes: begin
        if (!ovalid_q) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // control state, registers and cursor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StClr;
      clr_q    <= '0;
      base_q   <= PlaneBaseRst;
      lwidth_q <= LineWidthRst;
      lcount_q <= LineCountRst;
      cx_q     <= '0;
      cy_q     <= 8'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (cfg_we_i && cfg_idx_i == RegPlaneBase) begin
        base_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == RegLineWidth) begin
        lwidth_q <= cfg_data_i[8:0];
      end
      if (cfg_we_i && cfg_idx_i == RegLineCount) begin
        lcount_q <= cfg_data_i[7:0];
      end
      if (cfg_we_i && (cfg_idx_i == RegPlaneBase || cfg_idx_i == RegLineWidth ||
                       cfg_idx_i == RegLineCount)) begin
        cx_q <= '0;
        cy_q <= 8'd0;
      end else begin
        cx_q <= cx_d;
        cy_q <= cy_d;
      end
      if (load_out) begin
        ovalid_q <= 1'b1;
      end else if (pop_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      item_q <= item_i;
    end
    len_q   <= len_d;
    sx_q    <= sx_d;
    sn_q    <= sn_d;
    send_q  <= send_d;
    rel_q   <= rel_d;
    addr_q  <= addr_d;
    bidx_q  <= bidx_d;
    plane_q <= plane_d;
    rstat_q <= rstat_d;
    rrem_q  <= rrem_d;
    rdat_q  <= rdat_d;
    if (load_out) begin
      ostat_q <= rstat_q;
      orem_q  <= rrem_q;
      odat_q  <= rdat_q;
    end
  end

  // frame memory, one bank per array
  always_ff @(posedge clk_i) begin
    if (we0) begin
      mem0[wa] <= wd;
    end
    if (we1) begin
      mem1[wa] <= wd;
    end
    rd0_q  <= mem0[ra];
    rd1_q  <= mem1[ra];
    rsel_q <= rsel;
  end

  assign clearing_o         = (state_q == StClr);
  assign empty_o            = !ovalid_q;
  assign status_o           = ostat_q;
  assign remaining_length_o = orem_q;
  assign read_data_o        = odat_q;

endmodule

`default_nettype wire

FILE: sv/run_length_planar_span_fill_core.sv
// run_length_planar_span_fill_core: top level, front queue and span painting back end
// depends on rlsf_pkg, rlsf_front, rlsf_back
//
// Usage: input words enter on push_i while full_o is low; each word is either a
// run (command 0: level, run_length) painted at the raster cursor into a 4-plane,
// 2-bank frame memory, or a read (command 1) of one frame memory byte.
// Each word gives one result word, shown while empty_o is low and taken with pop_i.
// Registers are to be written via cfg_we_i/cfg_idx_i/cfg_data_i only while idle
// (the block itself does not enforce this); any write to a defined register
// returns the cursor to the top left corner.
// A run passes per word through take, dispatch and result steps, per line
// segment through setup and advance steps, plus, for each of the 4 planes, a
// setup step and one write step per covered byte (a partly covered byte is
// first read and then merged).
// After reset a clearing pass writes zero to every one of the 2^ADDR_BITS bytes
// (65536 by default) of each bank, during which full_o stays high.
// A stalled receiver holds the result register; the front queue takes two
// more words, then full_o rises.
`default_nettype none

module run_length_planar_span_fill_core #(
  parameter int unsigned ADDR_BITS  = rlsf_pkg::AddrBitsDef,
  parameter int unsigned ROW_BYTES  = rlsf_pkg::RowBytesDef,
  parameter int unsigned MAX_WIDTH  = rlsf_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = rlsf_pkg::MaxHeightDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        push_i,
  output logic             full_o,
  input  wire logic        command_i,
  input  wire logic [3:0]  level_i,
  input  wire logic [15:0] run_length_i,
  input  wire logic [15:0] read_address_i,
  input  wire logic        read_bank_i,
  output logic             empty_o,
  input  wire logic        pop_i,
  output logic [1:0]       status_o,
  output logic [15:0]      remaining_length_o,
  output logic [7:0]       read_data_o
);
  import rlsf_pkg::*;

  item_t item;
  logic  avail, take, clearing;

  // front: accept and classify
  rlsf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .command_i      (command_i),
    .level_i        (level_i),
    .run_length_i   (run_length_i),
    .read_address_i (read_address_i),
    .read_bank_i    (read_bank_i),
    .clearing_i     (clearing),
    .avail_o        (avail),
    .item_o         (item),
    .take_i         (take)
  );

  // back: paint, read and report
  rlsf_back #(
    .ADDR_BITS  (ADDR_BITS),
    .ROW_BYTES  (ROW_BYTES),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .avail_i            (avail),
    .item_i             (item),
    .take_o             (take),
    .clearing_o         (clearing),
    .empty_o            (empty_o),
    .pop_i              (pop_i),
    .status_o           (status_o),
    .remaining_length_o (remaining_length_o),
    .read_data_o        (read_data_o)
  );

endmodule

`default_nettype wire
